// File: rtl/core/heq_pkg.sv
// ----------------------------------------------------------------------------
// heq_pkg
// shared constants and types of the histogram equalizer
// ----------------------------------------------------------------------------
`default_nettype none

package heq_pkg;

	localparam int unsigned MAX_PIXELS = 4194304;
	localparam int unsigned LEVELS     = 256;
	localparam int unsigned LVL_W      = $clog2(LEVELS);
	localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
	localparam int unsigned NUM_W      = CNT_W + LVL_W;
	localparam int unsigned STEP_W     = $clog2(LVL_W);

	typedef logic [LVL_W-1:0]  level_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [NUM_W-1:0]  num_t;
	typedef logic [STEP_W-1:0] step_t;

	localparam level_t TOP_LEVEL = LVL_W'(LEVELS - 1);
	localparam count_t MAX_COUNT = CNT_W'(MAX_PIXELS);

	typedef struct packed {
		logic   clr;
		logic   rd_en;
		level_t rd_addr;
		logic   wr_en;
		level_t wr_addr;
		count_t wr_data;
	} bin_req_t;

endpackage

`default_nettype wire

// File: rtl/core/heq_if.sv
// ----------------------------------------------------------------------------
// heq_if
// valid/ready channels for pixel words in and equalized words out
// ----------------------------------------------------------------------------
`default_nettype none

interface heq_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] pixel;
	logic       last_pixel;

	modport source (output valid, kind, pixel, last_pixel, input ready);
	modport sink   (input valid, kind, pixel, last_pixel, output ready);
endinterface

interface heq_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_pixel;
	logic       overflow;

	modport source (output valid, out_pixel, overflow, input ready);
	modport sink   (input valid, out_pixel, overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/core/histogram_equalizer_unit.sv
// ----------------------------------------------------------------------------
// histogram_equalizer_unit
// two-pass 8-bit histogram equalizer: bin counting, table build, pixel mapping
// ----------------------------------------------------------------------------
// accumulate word: read-modify-write of one histogram bin, done before the next word
// map word: table read registered on acceptance, result then moved to the output
// register once it is free; no new word is taken before that
// table build after the marked pixel, per level: bin read, running sum, divider
// start and the 8-step divider
// reset clears the histogram valid bits at once; the mapping table is not cleared
`default_nettype none

module histogram_equalizer_unit import heq_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	heq_in_if.sink    pix_in,
	heq_out_if.source pix_out
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ACC    = 3'd1;
	localparam logic [2:0] S_MAP    = 3'd2;
	localparam logic [2:0] S_BRD    = 3'd3;
	localparam logic [2:0] S_BACC   = 3'd4;
	localparam logic [2:0] S_BSTART = 3'd5;
	localparam logic [2:0] S_BDIV   = 3'd6;

	logic [2:0] state_q;
	count_t     total_q;
	logic       overflow_q;
	logic       tbl_ready_q;
	logic       restart_q;
	level_t     pix_s1;
	logic       cnt_s1;
	logic       last_s1;
	level_t     g_q;
	count_t     cum_q;
	logic       out_valid_q;
	level_t     out_pixel_q;
	logic       out_ovf_q;

	logic       acc_go;
	logic       map_go;
	count_t     total_eff;
	logic       drop;
	logic       out_free;
	bin_req_t   bin_req;
	count_t     bin_rd;
	level_t     lut_rd;
	logic       div_done;
	level_t     div_quo;
	num_t       num;
	count_t     den;

	assign pix_in.ready = state_q == S_IDLE;
	assign acc_go       = pix_in.valid && pix_in.ready && !pix_in.kind;
	assign map_go       = pix_in.valid && pix_in.ready && pix_in.kind;
	assign total_eff    = restart_q ? '0 : total_q;
	assign drop         = total_eff >= MAX_COUNT;
	assign out_free     = !out_valid_q || pix_out.ready;

	assign pix_out.valid     = out_valid_q;
	assign pix_out.out_pixel = out_pixel_q;
	assign pix_out.overflow  = out_ovf_q;

	always_comb begin
		bin_req.clr     = acc_go && restart_q;
		bin_req.rd_en   = (acc_go && !drop) || state_q == S_BRD;
		bin_req.rd_addr = (state_q == S_BRD) ? g_q : pix_in.pixel;
		bin_req.wr_en   = state_q == S_ACC && cnt_s1;
		bin_req.wr_addr = pix_s1;
		bin_req.wr_data = bin_rd + CNT_W'(1);
	end

	// cumulative count times 255, over the pass total
	assign num = NUM_W'({cum_q, LVL_W'(0)}) - NUM_W'(cum_q);
	assign den = (total_q == '0) ? CNT_W'(1) : total_q;

	heq_bins u_bins (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (bin_req),
		.rd_data (bin_rd)
	);

	heq_lut u_lut (
		.clk     (clk),
		.wr_en   (state_q == S_BDIV && div_done),
		.wr_addr (g_q),
		.wr_data (div_quo),
		.rd_en   (map_go),
		.rd_addr (pix_in.pixel),
		.rd_data (lut_rd)
	);

	heq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_BSTART),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			overflow_q  <= 1'b0;
			tbl_ready_q <= 1'b0;
			restart_q   <= 1'b0;
			cnt_s1      <= 1'b0;
			last_s1     <= 1'b0;
			g_q         <= '0;
			cum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_MAP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_go) begin
						restart_q  <= 1'b0;
						overflow_q <= drop || (overflow_q && !restart_q);
						total_q    <= drop ? total_eff : total_eff + CNT_W'(1);
						cnt_s1     <= !drop;
						last_s1    <= pix_in.last_pixel;
						state_q    <= S_ACC;
					end else if (map_go) begin
						restart_q <= 1'b1;
						state_q   <= S_MAP;
					end
				end
				S_ACC: begin
					g_q     <= '0;
					cum_q   <= '0;
					state_q <= last_s1 ? S_BRD : S_IDLE;
				end
				S_MAP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_BRD: begin
					state_q <= S_BACC;
				end
				S_BACC: begin
					cum_q   <= cum_q + bin_rd;
					state_q <= S_BSTART;
				end
				S_BSTART: begin
					state_q <= S_BDIV;
				end
				S_BDIV: begin
					if (div_done) begin
						if (g_q == TOP_LEVEL) begin
							tbl_ready_q <= 1'b1;
							restart_q   <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							g_q     <= g_q + LVL_W'(1);
							state_q <= S_BRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_go || map_go) begin
			pix_s1 <= pix_in.pixel;
		end
		if (state_q == S_MAP && out_free) begin
			out_pixel_q <= tbl_ready_q ? lut_rd : pix_s1;
			out_ovf_q   <= overflow_q;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/heq_bins.sv
// ----------------------------------------------------------------------------
// heq_bins
// histogram bin memory with per-bin valid bits so one clear empties every bin
// ----------------------------------------------------------------------------
`default_nettype none

module heq_bins import heq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire bin_req_t req,
	output count_t        rd_data
);

	count_t            mem [LEVELS];
	count_t            rd_s1;
	logic              rd_valid_s1;
	logic [LEVELS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_s1 <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_s1 <= valid_q[req.rd_addr] & ~req.clr;
			end
		end
	end

	// bins never written since the last clear read as zero
	assign rd_data = rd_valid_s1 ? rd_s1 : '0;

endmodule

`default_nettype wire

// File: rtl/core/heq_lut.sv
// ----------------------------------------------------------------------------
// heq_lut
// level mapping table, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module heq_lut import heq_pkg::*; (
	input  wire logic   clk,
	input  wire logic   wr_en,
	input  wire level_t wr_addr,
	input  wire level_t wr_data,
	input  wire logic   rd_en,
	input  wire level_t rd_addr,
	output level_t      rd_data
);

	level_t mem [LEVELS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/heq_div.sv
// ----------------------------------------------------------------------------
// heq_div
// restoring divider, one quotient bit per cycle, eight-bit quotient
// ----------------------------------------------------------------------------
`default_nettype none

module heq_div import heq_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire num_t   num,
	input  wire count_t den,
	output logic        done,
	output level_t      quo
);

	num_t   rem_q;
	count_t den_q;
	step_t  step_q;
	logic   busy_q;
	num_t   trial;
	logic   fits;

	// numerator stays below 256 times the divisor, so eight bits suffice
	assign trial = NUM_W'(den_q) << step_q;
	assign fits  = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(LVL_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo   <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial;
			end
			quo <= {quo[LVL_W-2:0], fits};
		end
	end

endmodule

`default_nettype wire
